[design/plim_pkg.sv]
package plim_pkg;

  localparam int IRQ_COUNT_DEF   = 32;
  localparam int LEVEL_COUNT_DEF = 16;
  localparam int STACK_DEPTH_DEF = 16;

  localparam int VEC_W  = 5;
  localparam int LVL_W  = 4;
  localparam int MASK_W = 32;
  localparam int STS_W  = 2;

  typedef enum logic [1:0] {
    OP_UNMASK = 2'd0,
    OP_MASK   = 2'd1,
    OP_TAKE   = 2'd2,
    OP_RETURN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_NONE  = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } sts_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_EXEC = 2'd2,
    S_OUT  = 2'd3
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic walk_step;
    logic exec;
    logic out_load;
  } plim_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic walk_op;
    logic walk_done;
    logic out_free;
  } plim_sts_t;

endpackage

[design/plim_ctrl.sv]
module plim_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plim_pkg::plim_sts_t sts_i,
  output plim_pkg::plim_cmd_t cmd_o
);

  plim_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plim_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plim_pkg::S_IDLE: begin
        if (in_valid_i) state_d = plim_pkg::S_WALK;
      end
      plim_pkg::S_WALK: begin
        if (!sts_i.walk_op || sts_i.walk_done) state_d = plim_pkg::S_EXEC;
      end
      plim_pkg::S_EXEC: begin
        state_d = plim_pkg::S_OUT;
      end
      plim_pkg::S_OUT: begin
        if (sts_i.out_free) state_d = plim_pkg::S_IDLE;
      end
      default: state_d = plim_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      plim_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      plim_pkg::S_WALK: begin
        cmd_o.walk_step = sts_i.walk_op;
      end
      plim_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      plim_pkg::S_OUT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[design/plim_dp.sv]
module plim_dp #(
  parameter int IRQ_COUNT   = plim_pkg::IRQ_COUNT_DEF,
  parameter int LEVEL_COUNT = plim_pkg::LEVEL_COUNT_DEF,
  parameter int STACK_DEPTH = plim_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  plim_pkg::plim_cmd_t         cmd_i,
  output plim_pkg::plim_sts_t         sts_o,
  input  logic [1:0]                  operation_i,
  input  logic [plim_pkg::VEC_W-1:0]  vector_i,
  input  logic [plim_pkg::LVL_W-1:0]  level_i,
  input  logic [plim_pkg::MASK_W-1:0] pending_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [plim_pkg::MASK_W-1:0] enable_mask_o,
  output logic [plim_pkg::VEC_W-1:0]  chosen_vector_o,
  output logic                        vector_found_o,
  output logic [plim_pkg::LVL_W-1:0]  current_level_o,
  output logic [plim_pkg::STS_W-1:0]  status_o
);

  localparam int VIDX_W = (IRQ_COUNT > 1) ? $clog2(IRQ_COUNT) : 1;
  localparam int LIDX_W = $clog2(LEVEL_COUNT);
  localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [plim_pkg::VEC_W:0]    IRQ_LIM   = (plim_pkg::VEC_W + 1)'(IRQ_COUNT);
  localparam logic [plim_pkg::LVL_W-1:0]  LVL_MAX   = plim_pkg::LVL_W'(LEVEL_COUNT - 1);
  localparam logic [CNT_W-1:0]            STACK_LIM = CNT_W'(STACK_DEPTH);
  localparam logic [plim_pkg::MASK_W:0]   IRQ_ONES  =
    ((plim_pkg::MASK_W + 1)'(1) << IRQ_COUNT) - (plim_pkg::MASK_W + 1)'(1);
  localparam logic [plim_pkg::MASK_W-1:0] IRQ_MASK  = IRQ_ONES[plim_pkg::MASK_W-1:0];

  // latched item
  plim_pkg::op_e               op_q;
  logic [plim_pkg::VEC_W-1:0]  vec_q;
  logic [plim_pkg::LVL_W-1:0]  lvl_q;
  logic [plim_pkg::MASK_W-1:0] pend_q;

  // block state
  logic [plim_pkg::LVL_W-1:0]  lov_q   [IRQ_COUNT];
  logic [plim_pkg::MASK_W-1:0] mask_q  [LEVEL_COUNT];
  logic [plim_pkg::LVL_W-1:0]  saved_q [STACK_DEPTH];
  logic [plim_pkg::LVL_W-1:0]  lnow_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [LIDX_W-1:0]           walk_q;

  // per-item results
  logic [plim_pkg::VEC_W-1:0]  res_vec_q, res_vec_d;
  logic                        res_found_q, res_found_d;
  plim_pkg::sts_e              res_sts_q, res_sts_d;
  logic                        out_valid_q;

  logic                        in_range;
  logic [plim_pkg::MASK_W-1:0] pend_eff;
  logic [plim_pkg::VEC_W-1:0]  first_vec;
  logic                        any_pend;
  logic [VIDX_W-1:0]           lov_idx;
  logic [plim_pkg::LVL_W-1:0]  lov_rd;
  logic [plim_pkg::LVL_W-1:0]  limit;
  logic [plim_pkg::VEC_W-1:0]  walk_ext;
  logic                        mask_wr;
  logic [LIDX_W-1:0]           mask_idx;
  logic [plim_pkg::MASK_W-1:0] mask_rd;
  logic [plim_pkg::MASK_W-1:0] vec_bit;
  logic [plim_pkg::MASK_W-1:0] mask_new;
  logic                        can_push;
  logic                        out_take;
  logic [CNT_W-1:0]            cnt_dec;

  assign in_range = {1'b0, vec_q} < IRQ_LIM;
  assign pend_eff = pend_q & IRQ_MASK;
  assign any_pend = |pend_eff;

  // lowest-numbered pending vector
  always_comb begin
    first_vec = '0;
    for (int i = plim_pkg::MASK_W - 1; i >= 0; i--) begin
      if (pend_eff[i]) first_vec = plim_pkg::VEC_W'(i);
    end
  end

  assign lov_idx = (op_q == plim_pkg::OP_TAKE) ? first_vec[VIDX_W-1:0] : vec_q[VIDX_W-1:0];
  assign lov_rd  = lov_q[lov_idx];
  assign limit   = (op_q == plim_pkg::OP_UNMASK) ? lvl_q : lov_rd;

  assign walk_ext = plim_pkg::VEC_W'(walk_q);
  assign mask_wr  = cmd_i.walk_step && (walk_ext < plim_pkg::VEC_W'(limit));

  assign sts_o.walk_op   = ((op_q == plim_pkg::OP_UNMASK) || (op_q == plim_pkg::OP_MASK)) &&
                           in_range;
  assign sts_o.walk_done = (walk_ext + plim_pkg::VEC_W'(1)) >= plim_pkg::VEC_W'(limit);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // one read port: walked level during the walk, current level otherwise
  assign mask_idx = cmd_i.walk_step ? walk_q : lnow_q[LIDX_W-1:0];
  assign mask_rd  = mask_q[mask_idx];
  assign vec_bit  = plim_pkg::MASK_W'(1) << vec_q;
  assign mask_new = (op_q == plim_pkg::OP_UNMASK) ? (mask_rd | vec_bit) : (mask_rd & ~vec_bit);

  assign can_push = cnt_q < STACK_LIM;
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    res_vec_d   = '0;
    res_found_d = 1'b0;
    res_sts_d   = plim_pkg::STS_OK;
    case (op_q)
      plim_pkg::OP_TAKE: begin
        if (!any_pend) begin
          res_sts_d = plim_pkg::STS_NONE;
        end else begin
          res_vec_d   = first_vec;
          res_found_d = 1'b1;
          if (!can_push) res_sts_d = plim_pkg::STS_FULL;
        end
      end
      plim_pkg::OP_RETURN: begin
        if (cnt_q == '0) res_sts_d = plim_pkg::STS_EMPTY;
      end
      default: begin
        res_sts_d = plim_pkg::STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= plim_pkg::op_e'(operation_i);
      vec_q  <= vector_i;
      lvl_q  <= (level_i > LVL_MAX) ? LVL_MAX : level_i;
      pend_q <= pending_i;
    end
    if (cmd_i.load) begin
      walk_q <= '0;
    end else if (cmd_i.walk_step) begin
      walk_q <= walk_q + LIDX_W'(1);
    end
    if (cmd_i.exec && (op_q == plim_pkg::OP_TAKE) && any_pend && can_push) begin
      saved_q[cnt_q[SIDX_W-1:0]] <= lnow_q;
    end
    if (cmd_i.exec) begin
      res_vec_q   <= res_vec_d;
      res_found_q <= res_found_d;
      res_sts_q   <= res_sts_d;
    end
    if (cmd_i.out_load) begin
      enable_mask_o   <= mask_rd;
      chosen_vector_o <= res_vec_q;
      vector_found_o  <= res_found_q;
      current_level_o <= lnow_q;
      status_o        <= res_sts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < IRQ_COUNT; i++) lov_q[i] <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) mask_q[i] <= '0;
      lnow_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (mask_wr) mask_q[walk_q] <= mask_new;
      if (cmd_i.exec) begin
        case (op_q)
          plim_pkg::OP_UNMASK: begin
            if (in_range) lov_q[lov_idx] <= lvl_q;
          end
          plim_pkg::OP_MASK: begin
            if (in_range) lov_q[lov_idx] <= '0;
          end
          plim_pkg::OP_TAKE: begin
            if (any_pend && can_push) begin
              cnt_q <= cnt_q + CNT_W'(1);
              if (lov_rd > lnow_q) lnow_q <= lov_rd;
            end
          end
          default: begin
            if (cnt_q != '0) begin
              cnt_q  <= cnt_dec;
              lnow_q <= saved_q[cnt_dec[SIDX_W-1:0]];
            end
          end
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/priority_level_interrupt_masker_unit.sv]
// priority level interrupt masker
// input channel: in_valid_i / in_stall_o carries one item (operation, vector,
// level, pending); output channel: out_valid_o / out_stall_i carries one result
// per item (enable mask of the current level, chosen vector, found flag,
// current level, status).
// items are handled one at a time. after acceptance an item walks L level masks,
// where L is the new level on unmask, the recorded level on mask, and zero for
// take, return and a vector out of range; the result is then computed and moved
// into the output register. the walk of the level mask table goes one level per
// cycle through its single read-modify-write port; the next item is accepted
// only once the result is in the output register.
// a finished result sits in the output register until taken; while it is
// stalled the next item is still accepted and worked on, and only its final
// transfer into the output register waits.
// reset clears all vector levels, all level masks, the current level and the
// level stack; the block comes out of reset idle and ready to accept an item.
module priority_level_interrupt_masker_unit #(
  parameter int IRQ_COUNT   = plim_pkg::IRQ_COUNT_DEF,
  parameter int LEVEL_COUNT = plim_pkg::LEVEL_COUNT_DEF,
  parameter int STACK_DEPTH = plim_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [plim_pkg::VEC_W-1:0]  vector_i,
  input  logic [plim_pkg::LVL_W-1:0]  level_i,
  input  logic [plim_pkg::MASK_W-1:0] pending_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [plim_pkg::MASK_W-1:0] enable_mask_o,
  output logic [plim_pkg::VEC_W-1:0]  chosen_vector_o,
  output logic                        vector_found_o,
  output logic [plim_pkg::LVL_W-1:0]  current_level_o,
  output logic [plim_pkg::STS_W-1:0]  status_o
);

  plim_pkg::plim_cmd_t cmd;
  plim_pkg::plim_sts_t sts;

  plim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plim_dp #(
    .IRQ_COUNT   (IRQ_COUNT),
    .LEVEL_COUNT (LEVEL_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .vector_i        (vector_i),
    .level_i         (level_i),
    .pending_i       (pending_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .enable_mask_o   (enable_mask_o),
    .chosen_vector_o (chosen_vector_o),
    .vector_found_o  (vector_found_o),
    .current_level_o (current_level_o),
    .status_o        (status_o)
  );

endmodule

[sim/tb_priority_level_interrupt_masker_unit.sv]
`timescale 1ns / 100ps

module tb_priority_level_interrupt_masker_unit;

  localparam int NUM_VECTORS = plim_pkg::IRQ_COUNT_DEF;
  localparam int NUM_LEVELS  = plim_pkg::LEVEL_COUNT_DEF;
  localparam int NEST_LIMIT  = plim_pkg::STACK_DEPTH_DEF;
  localparam int VEC_W  = plim_pkg::VEC_W;
  localparam int LVL_W  = plim_pkg::LVL_W;
  localparam int MASK_W = plim_pkg::MASK_W;
  localparam int STS_W  = plim_pkg::STS_W;
  localparam int RANDOM_ITEMS = 1650;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AT_RESULT = 500;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    plim_pkg::op_e     op;
    logic [VEC_W-1:0]  vec;
    logic [LVL_W-1:0]  lvl;
    logic [MASK_W-1:0] pend;
  } irq_item_t;

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic [VEC_W-1:0]  chosen;
    logic              found;
    logic [LVL_W-1:0]  level;
    plim_pkg::sts_e    status;
  } irq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  plim_pkg::op_e operation = plim_pkg::OP_UNMASK;
  logic [VEC_W-1:0] vector = '0;
  logic [LVL_W-1:0] level = '0;
  logic [MASK_W-1:0] pending = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MASK_W-1:0] enable_mask;
  logic [VEC_W-1:0] chosen_vector;
  logic vector_found;
  logic [LVL_W-1:0] current_level;
  logic [STS_W-1:0] status;

  // masker state as the block should hold it
  logic [LVL_W-1:0]  vec_level [NUM_VECTORS];
  logic [MASK_W-1:0] level_masks [NUM_LEVELS];
  logic [LVL_W-1:0]  level_in_force;
  logic [LVL_W-1:0]  level_stack [NEST_LIMIT];
  int                nest_depth;

  irq_item_t   item_queue[$];
  irq_result_t expected_results[$];
  int items_planned = 0;
  int in_issued = 0;
  int in_accepted = 0;
  int results_seen = 0;
  int errors = 0;
  int idle_cycles = 0;

  priority_level_interrupt_masker_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .vector_i        (vector),
    .level_i         (level),
    .pending_i       (pending),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .enable_mask_o   (enable_mask),
    .chosen_vector_o (chosen_vector),
    .vector_found_o  (vector_found),
    .current_level_o (current_level),
    .status_o        (status)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic irq_result_t step_masker(input irq_item_t it);
    irq_result_t r;
    logic [LVL_W-1:0] lv;
    int first;
    r.chosen = '0;
    r.found = 1'b0;
    r.status = plim_pkg::STS_OK;
    case (it.op)
      plim_pkg::OP_UNMASK: begin
        if (it.vec < NUM_VECTORS) begin
          lv = (it.lvl > NUM_LEVELS - 1) ? LVL_W'(NUM_LEVELS - 1) : it.lvl;
          vec_level[it.vec] = lv;
          for (int i = 0; i < lv; i++) level_masks[i][it.vec] = 1'b1;
        end
      end
      plim_pkg::OP_MASK: begin
        if (it.vec < NUM_VECTORS) begin
          for (int i = 0; i < vec_level[it.vec]; i++) level_masks[i][it.vec] = 1'b0;
          vec_level[it.vec] = '0;
        end
      end
      plim_pkg::OP_TAKE: begin
        first = -1;
        for (int i = 0; i < NUM_VECTORS; i++) begin
          if (first < 0 && it.pend[i]) first = i;
        end
        if (first < 0) begin
          r.status = plim_pkg::STS_NONE;
        end else begin
          r.chosen = VEC_W'(first);
          r.found = 1'b1;
          if (nest_depth >= NEST_LIMIT) begin
            r.status = plim_pkg::STS_FULL;
          end else begin
            level_stack[nest_depth] = level_in_force;
            nest_depth++;
            if (vec_level[first] > level_in_force) level_in_force = vec_level[first];
          end
        end
      end
      default: begin
        if (nest_depth == 0) begin
          r.status = plim_pkg::STS_EMPTY;
        end else begin
          nest_depth--;
          level_in_force = level_stack[nest_depth];
        end
      end
    endcase
    r.mask = level_masks[level_in_force];
    r.level = level_in_force;
    return r;
  endfunction

  function automatic void add_item(input plim_pkg::op_e op, input logic [VEC_W-1:0] vec,
                                   input logic [LVL_W-1:0] lvl,
                                   input logic [MASK_W-1:0] pend);
    irq_item_t it;
    it.op = op;
    it.vec = vec;
    it.lvl = lvl;
    it.pend = pend;
    item_queue.push_back(it);
    items_planned++;
  endfunction

  function automatic logic [MASK_W-1:0] pick_pending();
    int sel;
    logic [MASK_W-1:0] one;
    sel = $urandom_range(0, 99);
    one = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
    if (sel < 8) return '0;
    if (sel < 40) return one;
    // a pending bit with random noise above it
    if (sel < 60) return one | ($urandom() & ~((one << 1) - 1));
    return $urandom();
  endfunction

  // mostly short gaps, a few long ones, and whole stretches with none
  function automatic int pick_gap(input int n);
    int sel;
    if ((n / 128) % 4 == 1) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver: presents items from the queue, changes inputs on the falling edge
  always @(negedge clk_i) begin
    int gap_left;
    irq_item_t it;
    if (rst_ni) begin
      if (in_valid && in_accepted != in_issued) begin
        // item still waiting to be taken, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_queue.size() != 0) begin
        it = item_queue.pop_front();
        operation <= it.op;
        vector <= it.vec;
        level <= it.lvl;
        pending <= it.pend;
        in_valid <= 1'b1;
        in_issued++;
        gap_left = pick_gap(in_issued);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    irq_item_t it;
    if (rst_ni && in_valid && !in_stall) begin
      it.op = operation;
      it.vec = vector;
      it.lvl = level;
      it.pend = pending;
      expected_results.push_back(step_masker(it));
      in_accepted++;
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    int stall_left;
    int hold_left;
    bit hold_done;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 2) == 0) ? pick_gap(results_seen) : 0;
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    irq_result_t exp_r;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: mask %h level %0d status %0d",
                 $time, enable_mask, current_level, status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (enable_mask !== exp_r.mask) begin
          $display("%0t: enable_mask expected %h actual %h", $time, exp_r.mask, enable_mask);
          errors++;
        end
        if (chosen_vector !== exp_r.chosen) begin
          $display("%0t: chosen_vector expected %0d actual %0d", $time, exp_r.chosen,
                   chosen_vector);
          errors++;
        end
        if (vector_found !== exp_r.found) begin
          $display("%0t: vector_found expected %b actual %b", $time, exp_r.found,
                   vector_found);
          errors++;
        end
        if (current_level !== exp_r.level) begin
          $display("%0t: current_level expected %0d actual %0d", $time, exp_r.level,
                   current_level);
          errors++;
        end
        if (status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, idle_cycles);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    int kind;
    int n;
    for (int i = 0; i < NUM_VECTORS; i++) vec_level[i] = '0;
    for (int i = 0; i < NUM_LEVELS; i++) level_masks[i] = '0;
    level_in_force = '0;
    nest_depth = 0;

    // directed: empty return, nothing pending, extreme vectors and levels,
    // nested takes with and without a level raise, re-unmask at a lower level
    add_item(plim_pkg::OP_RETURN, 5'd31, 4'd15, 32'hFFFF_FFFF);
    add_item(plim_pkg::OP_TAKE,   5'd0,  4'd0,  32'h0000_0000);
    add_item(plim_pkg::OP_UNMASK, 5'd0,  4'd15, 32'h0000_0000);
    add_item(plim_pkg::OP_UNMASK, 5'd31, 4'd1,  32'hA5A5_A5A5);
    add_item(plim_pkg::OP_UNMASK, 5'd5,  4'd7,  32'h5A5A_5A5A);
    add_item(plim_pkg::OP_TAKE,   5'd0,  4'd0,  32'h8000_0000);
    add_item(plim_pkg::OP_TAKE,   5'd31, 4'd15, 32'hFFFF_FFFF);
    add_item(plim_pkg::OP_TAKE,   5'd0,  4'd0,  32'h0000_0020);
    add_item(plim_pkg::OP_RETURN, 5'd0,  4'd0,  32'h0000_0000);
    add_item(plim_pkg::OP_RETURN, 5'd0,  4'd0,  32'h0000_0000);
    add_item(plim_pkg::OP_RETURN, 5'd0,  4'd0,  32'h0000_0000);
    add_item(plim_pkg::OP_RETURN, 5'd0,  4'd0,  32'h0000_0000);
    add_item(plim_pkg::OP_UNMASK, 5'd5,  4'd2,  32'hFFFF_FFFF);
    add_item(plim_pkg::OP_MASK,   5'd5,  4'd9,  32'h0000_0000);
    add_item(plim_pkg::OP_MASK,   5'd0,  4'd0,  32'h1234_5678);
    add_item(plim_pkg::OP_UNMASK, 5'd17, 4'd0,  32'h0000_0000);
    add_item(plim_pkg::OP_MASK,   5'd31, 4'd15, 32'hFFFF_FFFF);
    add_item(plim_pkg::OP_MASK,   5'd12, 4'd3,  32'h0000_0000);

    while (items_planned < RANDOM_ITEMS + 18) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        // reprogram a few vectors
        n = $urandom_range(1, 6);
        repeat (n) begin
          add_item(($urandom_range(0, 9) < 7) ? plim_pkg::OP_UNMASK : plim_pkg::OP_MASK,
                   VEC_W'($urandom()), LVL_W'($urandom()), $urandom());
        end
      end else if (kind < 80) begin
        // nested interrupts, sometimes deeper than the level stack
        n = $urandom_range(1, 20);
        repeat (n) begin
          add_item(plim_pkg::OP_TAKE, VEC_W'($urandom()), LVL_W'($urandom()),
                   pick_pending());
        end
        repeat ($urandom_range(0, n + 2)) begin
          add_item(plim_pkg::OP_RETURN, VEC_W'($urandom()), LVL_W'($urandom()),
                   $urandom());
        end
      end else begin
        add_item(plim_pkg::op_e'($urandom_range(0, 3)), VEC_W'($urandom()),
                 LVL_W'($urandom()), pick_pending());
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(in_accepted == items_planned && expected_results.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
